// ===== rtl/pli_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the positional list block.
// Used by pli_ctrl, pli_cell and the top level; depends on nothing.
package pli_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 5;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int TDATA_W   = 40;

  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage

// ===== rtl/pli_ctrl.sv =====
`timescale 1ns / 1ps
// Operation decoder: checks the request against the count and produces the
// shift command, target index, status and next count. Depends on pli_pkg.
module pli_ctrl import pli_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  position,
  input  logic [CW-1:0]     count,
  output cell_cmd_t         cmd,
  output logic [CW-1:0]     tgt,
  output logic [STAT_W-1:0] status,
  output logic [CW-1:0]     count_nxt,
  output logic              rd_ok
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          full;
  logic          empty;

  assign pos_w = PW'(position);
  assign cnt_w = PW'(count);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    cmd       = '0;
    tgt       = CW'(position);
    status    = ST_OK;
    count_nxt = count;
    rd_ok     = 1'b0;
    unique case (kind)
      KIND_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          tgt          = count;
          count_nxt    = count + CW'(1);
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = ST_BADPOS;
        end else begin
          cmd.shift_up = 1'b1;
          count_nxt    = count + CW'(1);
        end
      end
      KIND_DEL_FIRST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.shift_down = 1'b1;
          tgt            = '0;
          count_nxt      = count - CW'(1);
        end
      end
      KIND_DEL_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count - CW'(1);
        end
      end
      KIND_DEL_AT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          cmd.shift_down = 1'b1;
          count_nxt      = count - CW'(1);
        end
      end
      KIND_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

// ===== rtl/pli_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list row: holds one element and loads from its
// left or right neighbor or the new value. Depends on pli_pkg.
module pli_cell import pli_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  logic              en,
  input  cell_cmd_t         cmd,
  input  logic [CW-1:0]     tgt,
  input  logic [DATA_W-1:0] new_val,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val
);

  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (en && cmd.shift_up) begin
      if (IDX_V > tgt) begin
        val_nxt = left_val;
      end else if (IDX_V == tgt) begin
        val_nxt = new_val;
      end
    end else if (en && cmd.shift_down && IDX_V >= tgt) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Top level of the positional list: a row of element cells, the operation
// decoder and the result register. Depends on pli_pkg, pli_ctrl, pli_cell.
//
//  Channel | Direction | Signals                        | Contents
//  --------+-----------+--------------------------------+---------------------------
//  in_     | input     | in_tvalid/tready/tdata/tuser   | one list operation
//  out_    | output    | out_tvalid/tready/tdata/tuser  | status, read data, length
//
// Every operation finishes in the cycle of its transaction: each cell loads
// its left neighbor, its right neighbor or the new value in parallel, so the
// block sustains one transaction per cycle unless the output stalls. The
// result is in the output register in the cycle after its transaction. A
// stalled result blocks new input only while out_tready is low. Reset
// (rst_n low, synchronous) empties the list and drops any pending result;
// the cells are not cleared, as only entries below the count are ever read.
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [31:0] value, [36:32] position
  input  logic [KIND_W-1:0]  in_tuser,   // [2:0] kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [31:0] read_data, [36:32] length
  output logic [STAT_W-1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);
  // Positions are five bits wide, so at most the first 32 cells can be read.
  localparam int RN = (DEPTH < 32) ? DEPTH : 32;

  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_position;
  logic              in_xact;

  // Count of elements in use.
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  cell_cmd_t         cmd;
  logic [CW-1:0]     tgt;
  logic [STAT_W-1:0] status;
  logic              rd_ok;
  logic [DATA_W-1:0] rd_val;

  logic [DATA_W-1:0] cell_val [DEPTH];

  // Result register.
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] rdata_r;
  logic [LEN_W-1:0]  length_r;

  assign in_value    = in_tdata[DATA_W-1:0];
  assign in_position = in_tdata[DATA_W+POS_W-1:DATA_W];

  // A new transaction is taken whenever the result register is empty or is
  // being drained in this same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xact   = in_tvalid && in_tready;

  pli_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .kind      (in_tuser),
    .position  (in_position),
    .count     (count_r),
    .cmd       (cmd),
    .tgt       (tgt),
    .status    (status),
    .count_nxt (count_nxt),
    .rd_ok     (rd_ok)
  );

  // The row of cells. The first cell has no left neighbor and the last no
  // right neighbor; what they would load there lies beyond the list.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = in_value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    pli_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .en        (in_xact),
      .cmd       (cmd),
      .tgt       (tgt),
      .new_val   (in_value),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  // Read select over the addressable cells; zero unless the read is valid.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RN; i++) begin
      if (rd_ok && (in_position == POS_W'(i))) begin
        rd_val = cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xact) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The reported length is the count held in the low bits of the field.
  always_ff @(posedge clk) begin
    if (in_xact) begin
      status_r <= status;
      rdata_r  <= rd_val;
      length_r <= LEN_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(TDATA_W - DATA_W - LEN_W){1'b0}}, length_r, rdata_r};

endmodule
